[rtl/rope_pkg.sv]
`timescale 1ns / 1ps

package rope_pkg;

  // Head geometry and rotator depth.
  localparam int HALF_DIM     = 64;
  localparam int CORDIC_STEPS = 16;

  // Field widths.
  localparam int POS_W  = 16;
  localparam int IDX_W  = 6;
  localparam int DATA_W = 16;
  localparam int PAIRS  = 1 << IDX_W;

  // Internal widths: phase step in Q44 turns, phase in Q32 turns,
  // rotator vector in Q30 with headroom, residual angle in Q32 turns.
  localparam int STEP_W    = 42;
  localparam int PH_PROD_W = POS_W + STEP_W;
  localparam int PH_LSB    = 12;
  localparam int PHASE_W   = 32;
  localparam int CW        = 33;
  localparam int ZW        = 32;
  localparam int PROD_W    = DATA_W + CW;
  localparam int SUM_W     = PROD_W + 1;
  localparam int OUT_SHIFT = 30;
  localparam int SAT_W     = SUM_W - OUT_SHIFT;

  // Pipeline stage numbering.
  localparam int ST_LUT  = 0;
  localparam int ST_PH   = 1;
  localparam int ST_INIT = 2;
  localparam int ST_ROT0 = 3;
  localparam int ST_MAP  = ST_ROT0 + CORDIC_STEPS;
  localparam int ST_MUL  = ST_MAP + 1;
  localparam int ST_OUT  = ST_MUL + 1;
  localparam int NST     = ST_OUT + 1;

  // Decimal constants scaled by ten to the eighteenth.
  localparam logic [63:0] DEC_ONE        = 64'd1000000000000000000;
  localparam logic [63:0] LOG2_TEN_K_DEC = 64'd13287712379549449391;
  localparam logic [63:0] LN2_DEC        = 64'd693147180559945309;
  localparam logic [63:0] INV_TWO_PI_DEC = 64'd159154943091895336;
  localparam logic [63:0] Q50_MASK       = (64'd1 << 50) - 64'd1;

  // Quadrant of the phase, rounded to quarter turns.
  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } quad_t;

  typedef logic [PAIRS-1:0][STEP_W-1:0]    step_table_t;
  typedef logic [CORDIC_STEPS-1:0][ZW-1:0] atan_table_t;

  // Floor of a decimal fraction times two to the k.
  function automatic logic [63:0] dec_to_q(input logic [63:0] d, input int k);
    logic [63:0] q;
    logic [63:0] r;
    q = d / DEC_ONE;
    r = d % DEC_ONE;
    for (int i = 0; i < k; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= DEC_ONE) begin
        r    = r - DEC_ONE;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Low 64 bits of the full product shifted right.
  function automatic logic [63:0] umul_shr(input logic [63:0] a, input logic [63:0] b,
                                           input int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    return p[63:0];
  endfunction

  localparam logic [63:0] LOG2_TENK_Q50 = dec_to_q(LOG2_TEN_K_DEC, 50);
  localparam logic [63:0] LN2_Q60       = dec_to_q(LN2_DEC, 60);
  localparam logic [63:0] INV2PI_Q60    = dec_to_q(INV_TWO_PI_DEC, 60);

  // Integer square root, one result bit per pass.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v   = v_in;
    res = '0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bt > v) bt = bt >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bt != 64'd0) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // Rotator gain correction in Q30.
  function automatic logic [63:0] build_gain();
    logic [63:0] k2;
    logic [63:0] Den;
    k2 = 64'd1 << 60;
    for (int i = 0; i < CORDIC_STEPS && i < 31; i++) begin
      if (i == 0) begin
        k2 = k2 >> 1;
      end else begin
        Den = (64'd1 << (2 * i)) + 64'd1;
        k2  = k2 - k2 / Den;
      end
    end
    return isqrt64(k2);
  endfunction

  // Arctangent of two to the minus i, in Q32 turns; the first entry is one eighth turn.
  function automatic atan_table_t build_atan_table();
    atan_table_t tab;
    logic [63:0] sum;
    logic [63:0] tm;
    logic [63:0] val;
    logic        neg;
    tab    = '0;
    tab[0] = ZW'(64'd1 << 29);
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      sum = '0;
      neg = 1'b0;
      for (int M = 1; i * M <= 62; M += 2) begin
        tm  = (64'd1 << (62 - i * M)) / 64'(M);
        sum = neg ? sum - tm : sum + tm;
        neg = !neg;
      end
      val    = umul_shr(sum, INV2PI_Q60, 60) >> 30;
      tab[i] = val[ZW-1:0];
    end
    return tab;
  endfunction

  // Phase step per position for each pair index, in Q44 turns.
  function automatic step_table_t build_step_table();
    step_table_t tab;
    logic [63:0] e;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] yv;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] step60;
    logic [63:0] step44;
    logic [63:0] shift;
    tab = '0;
    for (int j = 0; j < PAIRS; j++) begin
      e    = (64'(j) * LOG2_TENK_Q50) / 64'(HALF_DIM);
      n    = e >> 50;
      f    = e & Q50_MASK;
      yv   = umul_shr(f << 10, LN2_Q60, 60);
      sum  = 64'd1 << 60;
      term = 64'd1 << 60;
      for (int K = 1; K <= 20; K++) begin
        term = umul_shr(term, yv, 60) / 64'(K);
        sum  = (K % 2 == 1) ? sum - term : sum + term;
      end
      step60 = umul_shr(sum, INV2PI_Q60, 60);
      shift  = n + 64'd16;
      step44 = (shift >= 64'd64) ? 64'd0 : (step60 >> shift);
      tab[j] = step44[STEP_W-1:0];
    end
    return tab;
  endfunction

  localparam step_table_t STEP_TABLE = build_step_table();
  localparam atan_table_t ATAN_TABLE = build_atan_table();
  localparam logic [63:0] GAIN_RAW   = build_gain();
  localparam logic signed [CW-1:0] GAIN_Q30 = GAIN_RAW[CW-1:0];

  // Rounding and saturation of the output products.
  localparam logic signed [SUM_W-1:0]  ROUND_BIAS = SUM_W'(1) << (OUT_SHIFT - 1);
  localparam logic signed [SAT_W-1:0]  SAT_HI     = SAT_W'(32767);
  localparam logic signed [SAT_W-1:0]  SAT_LO     = SAT_W'(-32768);
  localparam logic signed [DATA_W-1:0] Y_MAX      = DATA_W'(32767);
  localparam logic signed [DATA_W-1:0] Y_MIN      = DATA_W'(-32768);

  // Bounds used by the checks.
  localparam logic signed [ZW-1:0] Z_RES_LO = ZW'(-(2 ** 29));
  localparam logic signed [ZW-1:0] Z_RES_HI = ZW'(2 ** 29);
  localparam logic signed [CW-1:0] C_BOUND  = CW'((2 ** 30) + (2 ** 20));

endpackage

[rtl/rope_in_if.sv]
`timescale 1ns / 1ps

// Input channel: one element pair with its position and pair index per beat.
interface rope_in_if;
  logic                              valid;
  logic                              ready;
  logic [rope_pkg::POS_W-1:0]        position;
  logic [rope_pkg::IDX_W-1:0]        pair_index;
  logic signed [rope_pkg::DATA_W-1:0] x_first;
  logic signed [rope_pkg::DATA_W-1:0] x_second;

  modport source (output valid, position, pair_index, x_first, x_second, input ready);
  modport sink (input valid, position, pair_index, x_first, x_second, output ready);
endinterface

[rtl/rope_out_if.sv]
`timescale 1ns / 1ps

// Output channel: one rotated element pair per beat.
interface rope_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rope_pkg::DATA_W-1:0] y_first;
  logic signed [rope_pkg::DATA_W-1:0] y_second;

  modport source (output valid, y_first, y_second, input ready);
  modport sink (input valid, y_first, y_second, output ready);
endinterface

[rtl/rotary_position_embedding.sv]
`timescale 1ns / 1ps

// Channel | Side   | Beat contents
// rx      | sink   | position, pair_index, x_first, x_second
// tx      | source | y_first, y_second
//
// One beat enters per cycle while no stage is stalled; the stages are step lookup,
// phase multiply, quadrant split, one stage per CORDIC step, quadrant map,
// product and round/saturate.
// Reset (rst, synchronous) clears the stage valid bits only.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up and rx stays ready while empty stages remain.
module rotary_position_embedding (
  input  logic       clk,
  input  logic       rst,
  rope_in_if.sink    rx,
  rope_out_if.source tx
);

  logic [rope_pkg::NST-1:0] vld;
  logic [rope_pkg::NST-1:0] en;

  // Lookup stage.
  logic [rope_pkg::POS_W-1:0]  lut_pos;
  logic [rope_pkg::STEP_W-1:0] lut_step;

  // Element pair carried down to the quadrant map stage.
  logic signed [rope_pkg::DATA_W-1:0] xf [rope_pkg::ST_MUL];
  logic signed [rope_pkg::DATA_W-1:0] xs [rope_pkg::ST_MUL];

  // Phase stage.
  logic [rope_pkg::PH_PROD_W-1:0] ph_prod;
  logic [rope_pkg::PHASE_W-1:0]   ph_phase;

  // Quadrant split and rotator stages.
  logic [rope_pkg::PHASE_W-1:0] init_round;
  logic [rope_pkg::PHASE_W-1:0] init_rr;
  rope_pkg::quad_t              init_q;
  logic signed [rope_pkg::CW-1:0] cx [rope_pkg::CORDIC_STEPS+1];
  logic signed [rope_pkg::CW-1:0] cy [rope_pkg::CORDIC_STEPS+1];
  logic signed [rope_pkg::ZW-1:0] cz [rope_pkg::CORDIC_STEPS+1];
  rope_pkg::quad_t                qd [rope_pkg::CORDIC_STEPS+1];

  // Quadrant map, products and output.
  logic signed [rope_pkg::CW-1:0]     map_c_next;
  logic signed [rope_pkg::CW-1:0]     map_s_next;
  logic signed [rope_pkg::CW-1:0]     map_c;
  logic signed [rope_pkg::CW-1:0]     map_s;
  logic signed [rope_pkg::PROD_W-1:0] mul_fc;
  logic signed [rope_pkg::PROD_W-1:0] mul_ss;
  logic signed [rope_pkg::PROD_W-1:0] mul_sc;
  logic signed [rope_pkg::PROD_W-1:0] mul_fs;
  logic signed [rope_pkg::SUM_W-1:0]  sum_first;
  logic signed [rope_pkg::SUM_W-1:0]  sum_second;
  logic signed [rope_pkg::DATA_W-1:0] out_yf;
  logic signed [rope_pkg::DATA_W-1:0] out_ys;

  // Round half up at bit 30, then clamp to the 16-bit range.
  function automatic logic signed [rope_pkg::DATA_W-1:0] round_sat(
    input logic signed [rope_pkg::SUM_W-1:0] v
  );
    logic signed [rope_pkg::SUM_W-1:0] r;
    logic signed [rope_pkg::SAT_W-1:0] q;
    logic signed [rope_pkg::DATA_W-1:0] res;
    r = v + rope_pkg::ROUND_BIAS;
    q = r[rope_pkg::SUM_W-1:rope_pkg::OUT_SHIFT];
    if (q > rope_pkg::SAT_HI) begin
      res = rope_pkg::Y_MAX;
    end else if (q < rope_pkg::SAT_LO) begin
      res = rope_pkg::Y_MIN;
    end else begin
      res = q[rope_pkg::DATA_W-1:0];
    end
    return res;
  endfunction

  // A stage takes a new beat when it is empty or its contents move on.
  assign en[rope_pkg::NST-1] = !vld[rope_pkg::NST-1] || tx.ready;
  for (genvar gk = 0; gk < rope_pkg::NST - 1; gk++) begin : g_en
    assign en[gk] = !vld[gk] || en[gk+1];
  end

  assign rx.ready    = en[rope_pkg::ST_LUT];
  assign tx.valid    = vld[rope_pkg::NST-1];
  assign tx.y_first  = out_yf;
  assign tx.y_second = out_ys;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= rx.valid;
      for (int k = 1; k < rope_pkg::NST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Step lookup by pair index.
  always_ff @(posedge clk) begin
    if (en[rope_pkg::ST_LUT]) begin
      lut_pos              <= rx.position;
      lut_step             <= rope_pkg::STEP_TABLE[rx.pair_index];
      xf[rope_pkg::ST_LUT] <= rx.x_first;
      xs[rope_pkg::ST_LUT] <= rx.x_second;
    end
  end

  // Carry the element pair along the pipe.
  for (genvar gs = 1; gs <= rope_pkg::ST_MAP; gs++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en[gs]) begin
        xf[gs] <= xf[gs-1];
        xs[gs] <= xs[gs-1];
      end
    end
  end

  // Phase in Q32 turns: the middle bits of position times step.
  assign ph_prod = rope_pkg::PH_PROD_W'(lut_pos) * rope_pkg::PH_PROD_W'(lut_step);

  always_ff @(posedge clk) begin
    if (en[rope_pkg::ST_PH]) begin
      ph_phase <= ph_prod[rope_pkg::PH_LSB+rope_pkg::PHASE_W-1:rope_pkg::PH_LSB];
    end
  end

  // Split the phase into a quarter-turn quadrant and a residual within an eighth turn.
  assign init_round = ph_phase + rope_pkg::PHASE_W'(32'h2000_0000);
  assign init_q     = rope_pkg::quad_t'(init_round[rope_pkg::PHASE_W-1:rope_pkg::PHASE_W-2]);
  assign init_rr    = ph_phase - {init_round[rope_pkg::PHASE_W-1:rope_pkg::PHASE_W-2],
                                  {(rope_pkg::PHASE_W-2){1'b0}}};

  always_ff @(posedge clk) begin
    if (en[rope_pkg::ST_INIT]) begin
      cx[0] <= rope_pkg::GAIN_Q30;
      cy[0] <= '0;
      cz[0] <= signed'(init_rr);
      qd[0] <= init_q;
    end
  end

  // One CORDIC rotation step per stage.
  for (genvar gi = 0; gi < rope_pkg::CORDIC_STEPS; gi++) begin : g_rot
    logic signed [rope_pkg::CW-1:0] dx;
    logic signed [rope_pkg::CW-1:0] dy;
    logic signed [rope_pkg::ZW-1:0] at;

    assign dx = cx[gi] >>> gi;
    assign dy = cy[gi] >>> gi;
    assign at = signed'(rope_pkg::ATAN_TABLE[gi]);

    always_ff @(posedge clk) begin
      if (en[rope_pkg::ST_ROT0+gi]) begin
        if (!cz[gi][rope_pkg::ZW-1]) begin
          cx[gi+1] <= cx[gi] - dy;
          cy[gi+1] <= cy[gi] + dx;
          cz[gi+1] <= cz[gi] - at;
        end else begin
          cx[gi+1] <= cx[gi] + dy;
          cy[gi+1] <= cy[gi] - dx;
          cz[gi+1] <= cz[gi] + at;
        end
        qd[gi+1] <= qd[gi];
      end
    end
  end

  // Rotate cosine and sine back into the right quadrant.
  always_comb begin
    case (qd[rope_pkg::CORDIC_STEPS])
      rope_pkg::QUAD_0: begin
        map_c_next = cx[rope_pkg::CORDIC_STEPS];
        map_s_next = cy[rope_pkg::CORDIC_STEPS];
      end
      rope_pkg::QUAD_90: begin
        map_c_next = -cy[rope_pkg::CORDIC_STEPS];
        map_s_next = cx[rope_pkg::CORDIC_STEPS];
      end
      rope_pkg::QUAD_180: begin
        map_c_next = -cx[rope_pkg::CORDIC_STEPS];
        map_s_next = -cy[rope_pkg::CORDIC_STEPS];
      end
      default: begin
        map_c_next = cy[rope_pkg::CORDIC_STEPS];
        map_s_next = -cx[rope_pkg::CORDIC_STEPS];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[rope_pkg::ST_MAP]) begin
      map_c <= map_c_next;
      map_s <= map_s_next;
    end
  end

  // Four element-by-trig products.
  always_ff @(posedge clk) begin
    if (en[rope_pkg::ST_MUL]) begin
      mul_fc <= rope_pkg::PROD_W'(xf[rope_pkg::ST_MAP]) * rope_pkg::PROD_W'(map_c);
      mul_ss <= rope_pkg::PROD_W'(xs[rope_pkg::ST_MAP]) * rope_pkg::PROD_W'(map_s);
      mul_sc <= rope_pkg::PROD_W'(xs[rope_pkg::ST_MAP]) * rope_pkg::PROD_W'(map_c);
      mul_fs <= rope_pkg::PROD_W'(xf[rope_pkg::ST_MAP]) * rope_pkg::PROD_W'(map_s);
    end
  end

  // Combine, round and saturate into the output register.
  assign sum_first  = rope_pkg::SUM_W'(mul_fc) - rope_pkg::SUM_W'(mul_ss);
  assign sum_second = rope_pkg::SUM_W'(mul_sc) + rope_pkg::SUM_W'(mul_fs);

  always_ff @(posedge clk) begin
    if (en[rope_pkg::ST_OUT]) begin
      out_yf <= round_sat(sum_first);
      out_ys <= round_sat(sum_second);
    end
  end

  // An accepted beat always lands in the first stage.
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready) |=> vld[rope_pkg::ST_LUT])
    else $error("accepted beat did not enter the lookup stage");

  // The quadrant split leaves a residual within one eighth turn.
  a_residual: assert property (@(posedge clk) disable iff (rst)
    vld[rope_pkg::ST_INIT] |-> (cz[0] >= rope_pkg::Z_RES_LO && cz[0] < rope_pkg::Z_RES_HI))
    else $error("rotator residual outside one eighth turn");

  // The gain-corrected rotator keeps cosine and sine near unit size.
  a_trig_bound: assert property (@(posedge clk) disable iff (rst)
    vld[rope_pkg::ST_MAP] |->
      (map_c <= rope_pkg::C_BOUND && map_c >= -rope_pkg::C_BOUND &&
       map_s <= rope_pkg::C_BOUND && map_s >= -rope_pkg::C_BOUND))
    else $error("cosine or sine out of range");

  // Reset empties every stage.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

endmodule

[tb/sv/rotary_position_embedding_tb.sv]
`timescale 1ns / 1ps

module rotary_position_embedding_tb;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;

  // One rotated pair as it leaves the block.
  typedef struct packed {
    logic signed [rope_pkg::DATA_W-1:0] y_first;
    logic signed [rope_pkg::DATA_W-1:0] y_second;
  } rot_pair_t;

  // Predicts the rotation of each accepted beat and holds the pairs still owed.
  class rotation_predictor;
    logic [63:0] log2_q50;
    logic [63:0] ln2_q60;
    logic [63:0] inv2pi_q60;
    logic [63:0] step_q44 [1 << rope_pkg::IDX_W];
    longint      atan_q32 [rope_pkg::CORDIC_STEPS];
    longint      gain;
    rot_pair_t   owed_q [$];
    int          errors;

    // Floor of a decimal fraction, scaled by ten to the eighteenth, times two to the k.
    function logic [63:0] scaled_floor(logic [63:0] dec, int k);
      logic [127:0] wide;
      wide = {64'd0, dec} << k;
      wide = wide / 128'd1000000000000000000;
      return wide[63:0];
    endfunction

    // Full product, shifted right, low word kept.
    function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p >> sh;
      return p[63:0];
    endfunction

    function longint round_clip(longint v);
      longint r;
      r = (v + 64'sd536870912) >>> 30;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
    endfunction

    function new();
      logic [63:0] acc;
      logic [63:0] t;
      logic [63:0] k2;
      logic [63:0] root;
      logic [63:0] cand;
      logic [63:0] e;
      logic [63:0] n;
      logic [63:0] f;
      logic [63:0] yv;
      logic [63:0] term;
      logic [63:0] step60;
      logic [63:0] sh;
      bit          neg;
      errors     = 0;
      log2_q50   = scaled_floor(64'd13287712379549449391, 50);
      ln2_q60    = scaled_floor(64'd693147180559945309, 60);
      inv2pi_q60 = scaled_floor(64'd159154943091895336, 60);

      // Rotator angles in turns; the first one is an exact eighth of a turn.
      atan_q32[0] = longint'(1) << 29;
      for (int i = 1; i < rope_pkg::CORDIC_STEPS; i++) begin
        acc = '0;
        neg = 1'b0;
        for (int m = 1; i * m <= 62; m += 2) begin
          t   = (64'd1 << (62 - i * m)) / 64'(m);
          acc = neg ? acc - t : acc + t;
          neg = !neg;
        end
        atan_q32[i] = longint'(mul_shift(acc, inv2pi_q60, 60) >> 30);
      end

      // Start vector length: the reciprocal of the product of the stage gains.
      k2 = 64'd1 << 60;
      for (int i = 0; i < rope_pkg::CORDIC_STEPS && i < 31; i++) begin
        if (i == 0) k2 = k2 >> 1;
        else k2 = k2 - k2 / ((64'd1 << (2 * i)) + 64'd1);
      end
      root = '0;
      for (int b = 31; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= k2) root = cand;
      end
      gain = longint'(root);

      // Phase advance per position for every pair index.
      for (int j = 0; j < (1 << rope_pkg::IDX_W); j++) begin
        e    = (64'(j) * log2_q50) / 64'(rope_pkg::HALF_DIM);
        n    = e >> 50;
        f    = e & ((64'd1 << 50) - 64'd1);
        yv   = mul_shift(f << 10, ln2_q60, 60);
        acc  = 64'd1 << 60;
        term = 64'd1 << 60;
        for (int k = 1; k <= 20; k++) begin
          term = mul_shift(term, yv, 60) / 64'(k);
          acc  = (k % 2 == 1) ? acc - term : acc + term;
        end
        step60      = mul_shift(acc, inv2pi_q60, 60);
        sh          = n + 64'd16;
        step_q44[j] = (sh >= 64'd64) ? 64'd0 : (step60 >> sh);
      end
    endfunction

    function rot_pair_t rotate_pair(logic [rope_pkg::POS_W-1:0] pos,
                                    logic [rope_pkg::IDX_W-1:0] j,
                                    logic signed [rope_pkg::DATA_W-1:0] a,
                                    logic signed [rope_pkg::DATA_W-1:0] b);
      rot_pair_t          r;
      logic [63:0]        prod;
      logic [31:0]        phase;
      logic [31:0]        biased;
      logic [31:0]        resid;
      logic signed [31:0] zs;
      rope_pkg::quad_t    quad;
      longint             x, y, z, dx, dy, c, s;
      prod   = 64'(pos) * step_q44[j];
      phase  = prod[43:12];
      biased = phase + 32'h2000_0000;
      quad   = rope_pkg::quad_t'(biased[31:30]);
      resid  = phase - {biased[31:30], 30'd0};
      zs     = resid;
      z      = zs;
      x      = gain;
      y      = 0;
      for (int i = 0; i < rope_pkg::CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - atan_q32[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + atan_q32[i];
        end
      end
      // Fold the quadrant back in.
      case (quad)
        rope_pkg::QUAD_0: begin
          c = x;
          s = y;
        end
        rope_pkg::QUAD_90: begin
          c = -y;
          s = x;
        end
        rope_pkg::QUAD_180: begin
          c = -x;
          s = -y;
        end
        default: begin
          c = y;
          s = -x;
        end
      endcase
      r.y_first  = rope_pkg::DATA_W'(round_clip(longint'(a) * c - longint'(b) * s));
      r.y_second = rope_pkg::DATA_W'(round_clip(longint'(b) * c + longint'(a) * s));
      return r;
    endfunction

    function void note_pair(logic [rope_pkg::POS_W-1:0] pos, logic [rope_pkg::IDX_W-1:0] j,
                            logic signed [rope_pkg::DATA_W-1:0] a,
                            logic signed [rope_pkg::DATA_W-1:0] b);
      owed_q.insert(owed_q.size(), rotate_pair(pos, j, a, b));
    endfunction

    function void check_rotated(logic signed [rope_pkg::DATA_W-1:0] y1,
                                logic signed [rope_pkg::DATA_W-1:0] y2);
      rot_pair_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected output beat, actual %0d %0d", $time, y1, y2);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (want.y_first !== y1) begin
        $display("%0t: y_first mismatch, expected %0d, actual %0d",
                 $time, $signed(want.y_first), y1);
        errors++;
      end
      if (want.y_second !== y2) begin
        $display("%0t: y_second mismatch, expected %0d, actual %0d",
                 $time, $signed(want.y_second), y2);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   gaps_on;
  bit   stalls_on;
  int   hold_count;

  rotation_predictor rotations;

  rope_in_if  rx_bus ();
  rope_out_if tx_bus ();

  rotary_position_embedding u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_bus),
    .tx  (tx_bus)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offers one beat from a falling edge and returns at the falling edge after it is taken.
  task automatic send_item(input logic [rope_pkg::POS_W-1:0] pos,
                           input logic [rope_pkg::IDX_W-1:0] j,
                           input logic signed [rope_pkg::DATA_W-1:0] a,
                           input logic signed [rope_pkg::DATA_W-1:0] b);
    rx_bus.valid      = 1'b1;
    rx_bus.position   = pos;
    rx_bus.pair_index = j;
    rx_bus.x_first    = a;
    rx_bus.x_second   = b;
    @(posedge clk);
    while (!rx_bus.ready) @(posedge clk);
    rotations.note_pair(pos, j, a, b);
    @(negedge clk);
  endtask

  task automatic idle_input(input int cycles);
    rx_bus.valid      = 1'b0;
    rx_bus.position   = rope_pkg::POS_W'($urandom());
    rx_bus.pair_index = rope_pkg::IDX_W'($urandom());
    rx_bus.x_first    = rope_pkg::DATA_W'($urandom());
    rx_bus.x_second   = rope_pkg::DATA_W'($urandom());
    repeat (cycles) @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 5) == 0) idle_input($urandom_range(1, 10));
  endtask

  // Holds the input quiet until every owed pair has come out.
  task automatic wait_for_rotations();
    idle_input(1);
    while (rotations.outstanding() != 0) @(negedge clk);
  endtask

  // Random beat; some are biased towards corner values, short positions or high indexes.
  task automatic send_random();
    logic [rope_pkg::POS_W-1:0]         pos;
    logic [rope_pkg::IDX_W-1:0]         j;
    logic signed [rope_pkg::DATA_W-1:0] a;
    logic signed [rope_pkg::DATA_W-1:0] b;
    logic signed [rope_pkg::DATA_W-1:0] corner [4];
    int                                 kind;
    corner = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
    pos    = rope_pkg::POS_W'($urandom());
    j      = rope_pkg::IDX_W'($urandom());
    a      = rope_pkg::DATA_W'($urandom());
    b      = rope_pkg::DATA_W'($urandom());
    kind   = $urandom_range(0, 9);
    case (kind)
      0: begin
        a = corner[$urandom_range(0, 3)];
        b = corner[$urandom_range(0, 3)];
      end
      1: pos = rope_pkg::POS_W'($urandom_range(0, 15));
      2: j = rope_pkg::IDX_W'($urandom_range(rope_pkg::HALF_DIM - 8, rope_pkg::HALF_DIM - 1));
      default: ;
    endcase
    send_item(pos, j, a, b);
  endtask

  // Output side: random ready bursts, plus the long hold-off each time one is asked for.
  initial begin : sink_ready
    int holds_served;
    holds_served = 0;
    tx_bus.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (holds_served != hold_count) begin
        tx_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_served++;
        tx_bus.ready = 1'b1;
      end else if (stalls_on && $urandom_range(0, 6) == 0) begin
        tx_bus.ready = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        tx_bus.ready = 1'b1;
      end else begin
        tx_bus.ready = 1'b1;
      end
    end
  end

  // Every output beat is checked against the oldest owed pair.
  always @(posedge clk) begin
    if (!rst && tx_bus.valid && tx_bus.ready)
      rotations.check_rotated(tx_bus.y_first, tx_bus.y_second);
  end

  // Ends the run if no beat moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (rx_bus.valid && rx_bus.ready) || (tx_bus.valid && tx_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [rope_pkg::POS_W-1:0] row_pos;
    int                         sent;
    rotations         = new();
    rst               = 1'b1;
    gaps_on           = 1'b0;
    stalls_on         = 1'b0;
    hold_count        = 0;
    rx_bus.valid      = 1'b0;
    rx_bus.position   = '0;
    rx_bus.pair_index = '0;
    rx_bus.x_first    = '0;
    rx_bus.x_second   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed beats: zero phase, field extremes, every quadrant, saturation both ways
    // and an index whose step is so small that the pair passes nearly unchanged.
    send_item(16'd0, 6'd0, 16'sh7FFF, 16'sh8000);
    send_item(16'hFFFF, 6'd0, 16'sh8000, 16'sh7FFF);
    send_item(16'hFFFF, 6'd63, 16'sh7FFF, 16'sh7FFF);
    send_item(16'd1, 6'd0, 16'sh7FFF, 16'sh7FFF);
    send_item(16'd1, 6'd0, 16'sh8000, 16'sh8000);
    send_item(16'd2, 6'd0, 16'sd1024, 16'sd0);
    send_item(16'd3, 6'd0, 16'sd0, 16'sd1024);
    send_item(16'd4, 6'd0, -16'sd1024, 16'sd512);
    send_item(16'd5, 6'd0, 16'sd1024, -16'sd1024);
    send_item(16'd6, 6'd0, 16'sd1024, 16'sd1024);
    send_item(16'd7, 6'd0, 16'sh7FFF, 16'sh8000);
    send_item(16'd0, 6'd63, 16'sh8000, 16'sh8000);
    send_item(16'hFFFF, 6'd32, 16'sd12345, -16'sd12345);
    send_item(16'd100, 6'(rope_pkg::HALF_DIM - 1), -16'sd1, 16'sd1);
    send_item(16'hFFFF, 6'd1, 16'sd2047, -16'sd2048);
    send_item(16'd1, 6'd63, 16'sh7FFF, 16'sh8000);
    send_item(16'd40000, 6'd10, 16'sd0, 16'sd0);
    send_item(16'd32768, 6'd16, 16'sh5555, 16'shAAAA);
    send_item(16'hAAAA, 6'h2A, 16'shAAAA, 16'sh5555);
    send_item(16'h5555, 6'h15, 16'sh7FFF, 16'sh7FFF);
    wait_for_rotations();

    // The output holds off while beats keep coming, so the pipeline fills and stalls rx.
    hold_count++;
    repeat (40) send_random();
    wait_for_rotations();

    // Random beats in segments, each with its own mix of idling on the two sides.
    sent = 0;
    while (sent < 750) begin
      if (sent % 100 == 0) begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      send_random();
      maybe_gap();
      sent++;
    end

    // Whole head rows: one position swept over every pair index.
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    repeat (2) begin
      row_pos = rope_pkg::POS_W'($urandom());
      for (int j = 0; j < (1 << rope_pkg::IDX_W); j++) begin
        send_item(row_pos, rope_pkg::IDX_W'(j), rope_pkg::DATA_W'($urandom()),
                  rope_pkg::DATA_W'($urandom()));
        maybe_gap();
      end
    end

    // Closing stretch at full rate on both sides.
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (100) send_random();
    wait_for_rotations();
    repeat (rope_pkg::NST + 8) @(posedge clk);

    if (rotations.errors == 0 && rotations.outstanding() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
